FILE: sv/sacl_pkg.sv
// Shared constants, codes and result type of the set-associative cache controller.
// No dependencies; the interfaces, the core and the testbench import this package.
package sacl_pkg;

  localparam int SETS_DEFAULT       = 64;
  localparam int WAYS_DEFAULT       = 4;
  localparam int LINE_BYTES_DEFAULT = 16;

  localparam int ADDR_W    = 32;
  localparam int COUNT_W   = 32;
  localparam int WAY_OUT_W = 2;
  localparam int CFG_IDX_W = 2;

  // access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE_MODE = 2'd1;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic                 line_filled;
    logic                 victim_writeback;
    logic [ADDR_W-1:0]    victim_line_address;
    logic                 line_write_through;
    logic                 write_bypassed;
    logic [COUNT_W-1:0]   hit_total;
  } rsp_t;

endpackage

FILE: sv/sacl_if.sv
// Channel interfaces of the cache controller: access request, result, config write.
// Depends on sacl_pkg for field widths.
interface sacl_req_if;
  import sacl_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ADDR_W-1:0] address;
  modport source (output valid, operation, address, input ready);
  modport sink   (input valid, operation, address, output ready);
endinterface

interface sacl_rsp_if;
  import sacl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [WAY_OUT_W-1:0] way;
  logic                 line_filled;
  logic                 victim_writeback;
  logic [ADDR_W-1:0]    victim_line_address;
  logic                 line_write_through;
  logic                 write_bypassed;
  logic [COUNT_W-1:0]   hit_total;
  modport source (output valid, hit, way, line_filled, victim_writeback, victim_line_address,
                  line_write_through, write_bypassed, hit_total, input ready);
  modport sink   (input valid, hit, way, line_filled, victim_writeback, victim_line_address,
                  line_write_through, write_bypassed, hit_total, output ready);
endinterface

interface sacl_cfg_if;
  import sacl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic                 data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/set_assoc_cache_lru_controller_core.sv
// Top level of the set-associative cache tag/LRU controller (write-back/through, allocate).
// Depends on sacl_pkg and the channel interfaces in sacl_if.sv.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+------------------------------------------------
//   req     | in  | valid / ready | operation, address
//   rsp     | out | valid / ready | hit, way, line_filled, victim_writeback,
//           |     |               | victim_line_address, line_write_through,
//           |     |               | write_bypassed, hit_total
//   cfg     | in  | valid / ready | index, data (always ready)
//
// One request per cycle sustained while results are taken; the edge that takes a request
// also reads the set row from the tag memory, and lookup, replacement choice and update
// then run in the lookup stage, which writes them into the result register.
// A set written by the previous request is forwarded over the stale memory read.
// Reset (rst, synchronous) clears all valid bits at once, the counters and the modes
// (both modes come up as 1); no clearing pass. A stalled result holds the lookup stage,
// and req.ready drops only while the lookup stage and the result register are both full
// and the result is not being taken.
// SETS and LINE_BYTES must be powers of two.
module set_assoc_cache_lru_controller_core #(
  parameter int SETS       = sacl_pkg::SETS_DEFAULT,
  parameter int WAYS       = sacl_pkg::WAYS_DEFAULT,
  parameter int LINE_BYTES = sacl_pkg::LINE_BYTES_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  sacl_req_if.sink  req,
  sacl_rsp_if.source rsp,
  sacl_cfg_if.sink  cfg
);
  import sacl_pkg::*;

  localparam int OFF_BITS = $clog2(LINE_BYTES);
  localparam int IDX_BITS = $clog2(SETS);
  localparam int IDX_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int WAY_BITS = $clog2(WAYS);
  localparam int WAY_W    = (WAY_BITS > 0) ? WAY_BITS : 1;
  localparam int TAG_W    = ADDR_W - OFF_BITS - IDX_BITS;
  localparam int LEAVES   = 1 << WAY_BITS;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic               dirty;
    logic [COUNT_W-1:0] last_use;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  // ---------------------------------------------------------------------------
  // Configuration registers, used directly; user must write only while idle, unchecked.
  // ---------------------------------------------------------------------------
  logic write_back_mode;
  logic write_allocate_mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_back_mode     <= 1'b1;
      write_allocate_mode <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_WRITE_BACK_MODE:     write_back_mode     <= cfg.data;
        CFG_WRITE_ALLOCATE_MODE: write_allocate_mode <= cfg.data;
        default: ;  // indexes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake control
  // ---------------------------------------------------------------------------
  logic s1_valid;
  logic s1_adv;
  logic out_valid;
  logic req_fire;

  // advance the lookup stage when the result register is empty or being drained
  assign s1_adv   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;
  assign req_fire = req.valid && req.ready;

  // ---------------------------------------------------------------------------
  // Address split of the incoming request
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] req_set;
  logic [TAG_W-1:0] req_tag;

  assign req_set = IDX_W'((req.address >> OFF_BITS) & ADDR_W'(SETS - 1));
  assign req_tag = TAG_W'(req.address >> (OFF_BITS + IDX_BITS));

  // ---------------------------------------------------------------------------
  // Lookup stage registers and set-row memory
  // ---------------------------------------------------------------------------
  logic             s1_op;
  logic [IDX_W-1:0] s1_set;
  logic [TAG_W-1:0] s1_tag;
  logic             s1_fwd;
  row_t             fwd_row;
  row_t             rd_row;
  row_t             row_mem [SETS];
  row_t             row_cur;
  row_t             row_new;

  logic [SETS-1:0][WAYS-1:0] line_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_op   <= req.operation;
      s1_set  <= req_set;
      s1_tag  <= req_tag;
      // the memory read below misses an update written at this same edge
      s1_fwd  <= s1_adv && (s1_set == req_set);
      fwd_row <= row_new;
    end
  end

  // tag, dirty and last-use memory: one row per set, registered read
  always_ff @(posedge clk) begin
    if (req_fire) begin
      rd_row <= row_mem[req_set];
    end
    if (s1_adv) begin
      row_mem[s1_set] <= row_new;
    end
  end

  assign row_cur = s1_fwd ? fwd_row : rd_row;

  // ---------------------------------------------------------------------------
  // Lookup: tag match, first invalid way, LRU victim
  // ---------------------------------------------------------------------------
  logic [WAYS-1:0]  valid_set;
  logic [WAYS-1:0]  hit_vec;
  logic             hit_any;
  logic [WAY_W-1:0] hit_way;
  logic             inv_any;
  logic [WAY_W-1:0] inv_way;
  logic [WAY_W-1:0] lru_way;

  assign valid_set = line_valid[s1_set];

  always_comb begin
    hit_vec = '0;
    hit_way = '0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      hit_vec[w] = valid_set[w] && (row_cur[w].tag == s1_tag);
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!valid_set[w]) begin
        inv_way = WAY_W'(w);
      end
    end
    hit_any = |hit_vec;
    inv_any = !(&valid_set);
  end

  // minimum tree over last-use times; the left (lower) way wins ties
  logic [COUNT_W-1:0] node_time [2*LEAVES-1];
  logic [WAY_W-1:0]   node_way  [2*LEAVES-1];

  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      if (i < WAYS) begin
        node_time[LEAVES-1+i] = row_cur[i].last_use;
      end else begin
        node_time[LEAVES-1+i] = '1;
      end
      node_way[LEAVES-1+i] = WAY_W'(i);
    end
    for (int n = LEAVES - 2; n >= 0; n--) begin
      if (node_time[2*n+2] < node_time[2*n+1]) begin
        node_time[n] = node_time[2*n+2];
        node_way[n]  = node_way[2*n+2];
      end else begin
        node_time[n] = node_time[2*n+1];
        node_way[n]  = node_way[2*n+1];
      end
    end
    lru_way = node_way[0];
  end

  // ---------------------------------------------------------------------------
  // Policy: bypass, fill, victim, dirty / write-through, counters
  // ---------------------------------------------------------------------------
  logic               is_write;
  logic               bypass;
  logic               fill;
  logic [WAY_W-1:0]   sel;
  logic               victim_wb;
  logic [ADDR_W-1:0]  victim_addr;
  logic [COUNT_W-1:0] use_counter;
  logic [COUNT_W-1:0] use_counter_next;
  logic [COUNT_W-1:0] hit_counter;
  logic [COUNT_W-1:0] hit_counter_next;
  rsp_t               rsp_next;
  rsp_t               out_q;

  assign is_write  = (s1_op == OP_WRITE);
  assign bypass    = !hit_any && is_write && !write_allocate_mode;
  assign fill      = !hit_any && !bypass;
  assign sel       = hit_any ? hit_way : (inv_any ? inv_way : lru_way);
  // a victim exists only when every way of the set is valid
  assign victim_wb = fill && !inv_any && row_cur[lru_way].dirty;

  assign victim_addr = victim_wb
                     ? ((ADDR_W'(row_cur[lru_way].tag) << (OFF_BITS + IDX_BITS))
                        | (ADDR_W'(s1_set) << OFF_BITS))
                     : '0;

  // a bypassed write leaves the use counter alone
  assign use_counter_next = bypass ? use_counter : use_counter + COUNT_W'(1);
  assign hit_counter_next = hit_counter + COUNT_W'(hit_any);

  always_comb begin
    row_new = row_cur;
    if (!bypass) begin
      row_new[sel].last_use = use_counter_next;
      if (fill) begin
        row_new[sel].tag   = s1_tag;
        row_new[sel].dirty = 1'b0;
      end
      if (is_write && write_back_mode) begin
        row_new[sel].dirty = 1'b1;
      end
    end
  end

  always_comb begin
    rsp_next.hit                 = hit_any;
    rsp_next.way                 = bypass ? '0 : WAY_OUT_W'(sel);
    rsp_next.line_filled         = fill;
    rsp_next.victim_writeback    = victim_wb;
    rsp_next.victim_line_address = victim_addr;
    rsp_next.line_write_through  = !bypass && is_write && !write_back_mode;
    rsp_next.write_bypassed      = bypass;
    rsp_next.hit_total           = hit_counter_next;
  end

  // commit the lookup: valid bits, counters, result register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid  <= '0;
      use_counter <= '0;
      hit_counter <= '0;
    end else if (s1_adv) begin
      if (fill) begin
        line_valid[s1_set][sel] <= 1'b1;
      end
      use_counter <= use_counter_next;
      hit_counter <= hit_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_q <= rsp_next;
    end
  end

  assign rsp.valid               = out_valid;
  assign rsp.hit                 = out_q.hit;
  assign rsp.way                 = out_q.way;
  assign rsp.line_filled         = out_q.line_filled;
  assign rsp.victim_writeback    = out_q.victim_writeback;
  assign rsp.victim_line_address = out_q.victim_line_address;
  assign rsp.line_write_through  = out_q.line_write_through;
  assign rsp.write_bypassed      = out_q.write_bypassed;
  assign rsp.hit_total           = out_q.hit_total;

endmodule

FILE: sv/sacl_checker.sv
// Port-level checker of the cache controller and its bind to the top level.
// Depends only on the ports of set_assoc_cache_lru_controller_core.
module sacl_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_hit,
  input logic [1:0]  rsp_way,
  input logic        rsp_line_filled,
  input logic        rsp_victim_writeback,
  input logic [31:0] rsp_victim_line_address,
  input logic        rsp_line_write_through,
  input logic        rsp_write_bypassed,
  input logic [31:0] rsp_hit_total
);

  logic        req_fire;
  logic        rsp_fire;
  logic [31:0] total_seen;
  logic [1:0]  pending;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // track the last delivered hit total and requests still in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      total_seen <= '0;
      pending    <= '0;
    end else begin
      if (rsp_fire) begin
        total_seen <= rsp_hit_total;
      end
      pending <= pending + 2'(req_fire) - 2'(rsp_fire);
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_hit, rsp_way, rsp_line_filled,
      rsp_victim_writeback, rsp_victim_line_address, rsp_line_write_through,
      rsp_write_bypassed, rsp_hit_total}))
    else $error("stalled result changed");

  a_hit_total: assert property (@(posedge clk) disable iff (rst)
    rsp_fire |-> rsp_hit_total == total_seen + 32'(rsp_hit))
    else $error("hit total does not follow hits");

  a_outcome: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!(rsp_hit && rsp_line_filled))
               && (!rsp_victim_writeback || rsp_line_filled)
               && (!rsp_write_bypassed || (!rsp_hit && rsp_way == 2'd0 && !rsp_line_filled
                                           && !rsp_line_write_through)))
    else $error("inconsistent hit, fill, victim and bypass flags");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result without a pending request");

endmodule

bind set_assoc_cache_lru_controller_core sacl_checker u_sacl_checker (
  .clk                     (clk),
  .rst                     (rst),
  .req_valid               (req.valid),
  .req_ready               (req.ready),
  .rsp_valid               (rsp.valid),
  .rsp_ready               (rsp.ready),
  .rsp_hit                 (rsp.hit),
  .rsp_way                 (rsp.way),
  .rsp_line_filled         (rsp.line_filled),
  .rsp_victim_writeback    (rsp.victim_writeback),
  .rsp_victim_line_address (rsp.victim_line_address),
  .rsp_line_write_through  (rsp.line_write_through),
  .rsp_write_bypassed      (rsp.write_bypassed),
  .rsp_hit_total           (rsp.hit_total)
);

FILE: tb/sv/tb.sv
// Self-checking testbench for set_assoc_cache_lru_controller_core: tag/LRU lookup, fill,
// victim writeback, write-through and write-around, checked against a predictor of its own.
// Depends on sacl_pkg, the channel interfaces in sacl_if.sv and the core itself.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sacl_pkg::*;

  localparam int SETS       = SETS_DEFAULT;
  localparam int WAYS       = WAYS_DEFAULT;
  localparam int LINE_BYTES = LINE_BYTES_DEFAULT;
  localparam int LINES      = SETS * WAYS;
  localparam int OFS_W      = $clog2(LINE_BYTES);
  localparam int SET_W      = $clog2(SETS);
  localparam int TAG_W      = ADDR_W - OFS_W - SET_W;

  // register indexes past the end of the list; the core must ignore them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam int IDLE_PCT       = 19;
  localparam int PHASES         = 5;
  localparam int ITEMS_PER_PASS = 130;

  typedef enum logic {ROW_ACCESS, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic                 op;
    logic [ADDR_W-1:0]    addr;
    logic                 typed;   // compare against want instead of the predictor
    rsp_t                 want;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 reg_val;
  } plan_row_t;

  logic clk;
  logic rst;

  sacl_req_if req_ch ();
  sacl_rsp_if rsp_ch ();
  sacl_cfg_if cfg_ch ();

  set_assoc_cache_lru_controller_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Predicted cache directory: tags, valid and dirty bits, last-use stamps per line.
  logic [TAG_W-1:0]   line_tags  [LINES];
  logic               line_live  [LINES];
  logic               line_soiled[LINES];
  logic [COUNT_W-1:0] last_touch [LINES];
  logic [COUNT_W-1:0] touch_count;
  logic [COUNT_W-1:0] hit_count;
  logic               write_back_on;
  logic               allocate_on;

  rsp_t      results_due[$];   // expected results, oldest first
  plan_row_t plan[$];          // directed stimulus table
  int        mismatches;
  bit        calm;             // suppress idling on both sides

  // Hot pools keep most random accesses on a few sets so hits and evictions happen.
  logic [TAG_W-1:0] hot_tags[6];
  logic [SET_W-1:0] hot_sets[4];

  bit phase_wb   [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  bit phase_alloc[PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Work out the result of one access and advance the predicted directory.
  function automatic rsp_t predict_access(logic op, logic [ADDR_W-1:0] addr);
    rsp_t               r;
    logic [SET_W-1:0]   set_i;
    logic [TAG_W-1:0]   tg;
    int                 base;
    int                 sel;
    bit                 found;
    bit                 spare;
    logic [COUNT_W-1:0] oldest;
    r     = '0;
    set_i = addr[OFS_W +: SET_W];
    tg    = addr[ADDR_W-1 -: TAG_W];
    base  = int'(set_i) * WAYS;
    sel   = 0;
    found = 1'b0;
    spare = 1'b0;
    for (int w = 0; w < WAYS; w++)
      if (!found && line_live[base+w] && line_tags[base+w] == tg) begin
        sel   = w;
        found = 1'b1;
      end
    if (found) begin
      r.hit     = 1'b1;
      hit_count = hit_count + 1'b1;
    end else if (op == OP_WRITE && !allocate_on) begin
      r.write_bypassed = 1'b1;
    end else begin
      // first free way, else least recently used with the lowest way on ties
      for (int w = 0; w < WAYS; w++)
        if (!spare && !line_live[base+w]) begin
          sel   = w;
          spare = 1'b1;
        end
      if (!spare) begin
        oldest = last_touch[base];
        sel    = 0;
        for (int w = 1; w < WAYS; w++)
          if (last_touch[base+w] < oldest) begin
            oldest = last_touch[base+w];
            sel    = w;
          end
        if (line_soiled[base+sel]) begin
          r.victim_writeback    = 1'b1;
          r.victim_line_address = {line_tags[base+sel], set_i, {OFS_W{1'b0}}};
        end
      end
      line_tags[base+sel]   = tg;
      line_live[base+sel]   = 1'b1;
      line_soiled[base+sel] = 1'b0;
      r.line_filled         = 1'b1;
    end
    if (!r.write_bypassed) begin
      touch_count          = touch_count + 1'b1;
      last_touch[base+sel] = touch_count;
      if (op == OP_WRITE) begin
        if (write_back_on)
          line_soiled[base+sel] = 1'b1;
        else
          r.line_write_through = 1'b1;
      end
    end else begin
      sel = 0;
    end
    r.way       = sel[WAY_OUT_W-1:0];
    r.hit_total = hit_count;
    return r;
  endfunction

  function automatic void add_access(logic op, logic [ADDR_W-1:0] addr);
    plan.push_back('{ROW_ACCESS, op, addr, 1'b0, rsp_t'('0), CFG_WRITE_BACK_MODE, 1'b0});
  endfunction

  function automatic void add_checked(logic op, logic [ADDR_W-1:0] addr, rsp_t want);
    plan.push_back('{ROW_ACCESS, op, addr, 1'b1, want, CFG_WRITE_BACK_MODE, 1'b0});
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic val);
    plan.push_back('{ROW_REG, OP_READ, '0, 1'b0, rsp_t'('0), idx, val});
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    logic [OFS_W-1:0] ofs;
    ofs = OFS_W'($urandom_range(0, LINE_BYTES - 1));
    if ($urandom_range(0, 99) < 12)
      return $urandom;
    return {hot_tags[$urandom_range(0, 5)], hot_sets[$urandom_range(0, 3)], ofs};
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Issue one access request; return at the edge where it is taken.
  // valid stays high afterwards so back-to-back requests need no second assignment.
  task automatic send_access(logic op, logic [ADDR_W-1:0] addr, logic typed, rsp_t want);
    rsp_t predicted;
    if (!calm)
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.address   <= addr;
    @(posedge clk);
    while (!req_ch.ready)
      @(posedge clk);
    predicted = predict_access(op, addr);
    results_due.push_back(typed ? want : predicted);
  endtask

  // Drop the request valid and hold until every result is back, then let the pipe empty.
  task automatic settle_pipeline();
    req_ch.valid <= 1'b0;
    while (results_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one mode register; only called with the core idle.
  // End with an idle edge after the write so a following write starts on a fresh edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready)
      @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_WRITE_BACK_MODE)
      write_back_on = val;
    else if (idx == CFG_WRITE_ALLOCATE_MODE)
      allocate_on = val;
    @(posedge clk);
  endtask

  // Result side: compare each taken result with the oldest expectation, stall at random.
  initial begin
    rsp_t seen;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        seen = {rsp_ch.hit, rsp_ch.way, rsp_ch.line_filled, rsp_ch.victim_writeback,
                rsp_ch.victim_line_address, rsp_ch.line_write_through,
                rsp_ch.write_bypassed, rsp_ch.hit_total};
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          rsp_t want;
          want = results_due.pop_front();
          check_field("hit", 32'(seen.hit), 32'(want.hit));
          check_field("way", 32'(seen.way), 32'(want.way));
          check_field("line_filled", 32'(seen.line_filled), 32'(want.line_filled));
          check_field("victim_writeback", 32'(seen.victim_writeback),
                      32'(want.victim_writeback));
          check_field("victim_line_address", seen.victim_line_address,
                      want.victim_line_address);
          check_field("line_write_through", 32'(seen.line_write_through),
                      32'(want.line_write_through));
          check_field("write_bypassed", 32'(seen.write_bypassed),
                      32'(want.write_bypassed));
          check_field("hit_total", seen.hit_total, want.hit_total);
        end
      end
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Stimulus: directed table first, then random passes over every mode setting.
  initial begin
    mismatches = 0;
    calm       = 1'b0;
    for (int i = 0; i < LINES; i++) begin
      line_tags[i]   = '0;
      line_live[i]   = 1'b0;
      line_soiled[i] = 1'b0;
      last_touch[i]  = '0;
    end
    touch_count   = '0;
    hit_count     = '0;
    write_back_on = 1'b1;
    allocate_on   = 1'b1;

    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_READ;
    req_ch.address   <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_WRITE_BACK_MODE;
    cfg_ch.data      <= 1'b0;

    // Directed rows. Typed results list fields in rsp_t order: hit, way, filled,
    // victim writeback, victim address, write-through, bypass, hit total.
    add_checked(OP_READ,  32'h0000_0000, rsp_t'({1'b0, 2'd0, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0, 32'd0}));
    add_checked(OP_READ,  32'h0000_000C, rsp_t'({1'b1, 2'd0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 32'd1}));
    add_checked(OP_WRITE, 32'hFFFF_FFFF, rsp_t'({1'b0, 2'd0, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0, 32'd1}));
    add_checked(OP_READ,  32'hFFFF_FFF0, rsp_t'({1'b1, 2'd0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 32'd2}));
    // fill the rest of the top set with dirty lines
    add_access(OP_WRITE, 32'h0000_03F0);
    add_access(OP_WRITE, 32'h0000_07F0);
    add_access(OP_WRITE, 32'h0000_0BF0);
    // set full: least recently used way 0 is dirty and goes back to memory
    add_checked(OP_READ,  32'h0000_0FF0,
                rsp_t'({1'b0, 2'd0, 1'b1, 1'b1, 32'hFFFF_FFF0, 1'b0, 1'b0, 32'd2}));
    add_access(OP_WRITE, 32'h0000_0FF4);
    // write-through: a write hit sends the line, dirty bit left alone
    add_reg(CFG_WRITE_BACK_MODE, 1'b0);
    add_access(OP_WRITE, 32'h0000_03F8);
    // write-around: a write miss goes straight to memory and touches nothing
    add_reg(CFG_WRITE_ALLOCATE_MODE, 1'b0);
    add_checked(OP_WRITE, 32'h1234_5670,
                rsp_t'({1'b0, 2'd0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b1, 32'd4}));
    add_access(OP_READ,  32'h1234_5670);
    add_access(OP_WRITE, 32'h1234_567C);
    // writes past the register list must change nothing
    add_reg(CFG_SPARE_LO, 1'b1);
    add_reg(CFG_SPARE_HI, 1'b1);
    add_access(OP_WRITE, 32'h8000_0000);
    add_reg(CFG_WRITE_BACK_MODE, 1'b1);
    add_reg(CFG_WRITE_ALLOCATE_MODE, 1'b1);
    add_access(OP_WRITE, 32'h0000_13F0);
    add_access(OP_READ,  32'h0000_0000);
    add_access(OP_WRITE, 32'h7FFF_FFFF);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle_pipeline();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_access(plan[i].op, plan[i].addr, plan[i].typed, plan[i].want);
      end
    end

    hot_tags[0] = '0;
    hot_tags[1] = '1;
    hot_sets[0] = '0;
    hot_sets[1] = '1;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle_pipeline();
      write_reg(CFG_WRITE_BACK_MODE, phase_wb[ph]);
      write_reg(CFG_WRITE_ALLOCATE_MODE, phase_alloc[ph]);
      // refresh part of the hot pools so each pass sees fresh conflicts
      for (int k = 2; k < 6; k++)
        hot_tags[k] = TAG_W'($urandom);
      for (int k = 2; k < 4; k++)
        hot_sets[k] = SET_W'($urandom_range(0, SETS - 1));
      for (int n = 0; n < ITEMS_PER_PASS; n++) begin
        calm = (ph == 1 && n >= 20 && n < 110);
        // hold the sender once until everything in flight has come back
        if (ph == 0 && n == 60)
          settle_pipeline();
        send_access(1'($urandom_range(0, 1)), pick_address(), 1'b0, rsp_t'('0));
      end
    end
    calm = 1'b0;

    settle_pipeline();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
